>>> design/arip_pkg.sv
// Shared types and character constants for the ASCII radix integer parser.
package arip_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;

   localparam int unsigned RADIX_W     = 5;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam int unsigned VALUE_W     = 64;
   localparam int unsigned OFFSET_W    = 9;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_MODE = 1'b1;

   localparam logic [RADIX_W-1:0] RADIX_RESET     = 5'd10;
   localparam logic               WIDE_MODE_RESET = 1'b1;

   // Weight given to a character that is not a digit.
   localparam logic [4:0] DIGIT_NONE = 5'd16;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] stop_offset;
   } rsp_type;

   // Character class of one word, as seen by the back end.
   typedef struct packed {
      logic [4:0] digit;
      logic       is_nul;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
      logic       is_zero;
      logic       last;
   } cls_type;

endpackage

>>> design/arip_front.sv
// Front end: accepts input words and classifies each character.
module arip_front
   import arip_pkg::*;
(
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cls_type q_data
);

   logic [7:0] ch;

   assign ch        = req_data.ch;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data          = '0;
      q_data.last     = req_data.last;
      q_data.is_nul   = (ch == CH_NUL);
      q_data.is_space = (ch == CH_SPACE) || (ch == CH_TAB);
      q_data.is_minus = (ch == CH_MINUS);
      q_data.is_plus  = (ch == CH_PLUS);
      q_data.is_zero  = (ch == CH_0);
      q_data.digit    = DIGIT_NONE;
      if (ch inside {[CH_0:CH_9]}) begin
         q_data.digit = 5'(ch - CH_0);
      end else if (ch inside {[CH_UA:CH_UF]}) begin
         q_data.digit = 5'(ch - CH_UA + 8'd10);
      end else if (ch inside {[CH_LA:CH_LF]}) begin
         q_data.digit = 5'(ch - CH_LA + 8'd10);
      end
   end

endmodule

>>> design/arip_queue.sv
// Short queue of classified words between front and back end.
module arip_queue
   import arip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    q_valid,
   output cls_type q_data
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cls_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = mem_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/arip_back.sv
// Back end: parse state machine, radix multiply-add and result register.
module arip_back
   import arip_pkg::*;
#(
   parameter int unsigned MAX_LEN = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cls_type            q_data,
   output logic               q_pop,
   input  logic [RADIX_W-1:0] radix,
   input  logic               wide_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   localparam int unsigned POS_W = $clog2(MAX_LEN + 1);

   localparam logic [2:0] PH_WS     = 3'd0;
   localparam logic [2:0] PH_SIGN   = 3'd1;
   localparam logic [2:0] PH_ZEROS  = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_STOP   = 3'd4;

   logic [2:0]         phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   stop_ff, stop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [VALUE_W+RADIX_W-1:0] prod;
   logic [VALUE_W-1:0]         value;
   logic [POS_W-1:0]           off;
   logic [POS_W+OFFSET_W-1:0]  off_ext;
   logic                       consumed;
   logic                       digit_ok;

   // a word with last waits only while an unread result is held
   assign q_pop     = q_valid && (!q_data.last || !rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign prod     = acc_ff * radix;
   // a non-digit weighs 16, so a radix above 16 takes it as well; NUL always stops
   assign digit_ok = !q_data.is_nul && (q_data.digit < radix);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      consumed = 1'b0;

      if (pos_ff >= POS_W'(MAX_LEN)) begin
         // string longer than MAX_LEN: the rest is not examined
         if (phase_ff != PH_STOP) begin
            stop_in  = POS_W'(MAX_LEN);
            phase_in = PH_STOP;
         end
      end else begin
         pos_in = pos_ff + 1'b1;
         if (phase_ff != PH_STOP) begin
            if (phase_in == PH_WS) begin
               if (q_data.is_space) begin
                  consumed = 1'b1;
               end else begin
                  phase_in = PH_SIGN;
               end
            end
            if (!consumed && phase_in == PH_SIGN) begin
               phase_in = PH_ZEROS;
               if (q_data.is_minus) begin
                  neg_in   = 1'b1;
                  consumed = 1'b1;
               end else if (q_data.is_plus) begin
                  consumed = 1'b1;
               end
            end
            if (!consumed && phase_in == PH_ZEROS) begin
               if (q_data.is_zero) begin
                  consumed = 1'b1;
               end else begin
                  phase_in = PH_DIGITS;
               end
            end
            if (!consumed) begin
               if (digit_ok) begin
                  acc_in = prod[VALUE_W-1:0] + VALUE_W'(q_data.digit);
               end else begin
                  stop_in  = pos_ff;
                  phase_in = PH_STOP;
               end
            end
         end
      end

      value = neg_in ? (VALUE_W'(0) - acc_in) : acc_in;
      if (!wide_mode) begin
         value[VALUE_W-1:32] = '0;
      end
      off     = (phase_in == PH_STOP) ? stop_in : pos_in;
      off_ext = {{OFFSET_W{1'b0}}, off};

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (q_pop && q_data.last) begin
         rsp_valid_in       = 1'b1;
         rsp_in.value       = value;
         rsp_in.stop_offset = off_ext[OFFSET_W-1:0];
         // next string starts fresh
         phase_in = PH_WS;
         acc_in   = '0;
         neg_in   = 1'b0;
         pos_in   = '0;
         stop_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WS;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         pos_ff       <= '0;
         stop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            pos_ff   <= pos_in;
            stop_ff  <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> design/ascii_radix_integer_parser.sv
// Top level of the ASCII radix integer parser.
// Usage:
//   req_*  : one character word per transfer (ch, last). Leading spaces and
//            tabs, an optional sign and leading zeros are skipped, then digits
//            in the current radix are accumulated until a non-digit or NUL.
//   rsp_*  : one result word per string, sent for the word marked last:
//            value (two's complement, 32- or 64-bit wrap) and stop_offset.
//   csr_*  : write-only registers, index 0 radix, index 1 wide_mode; write
//            only while no string is in flight.
// Throughput: one character word per cycle, unless a held result stalls a
//   last word. The limit is the back end's 64 x 5 bit multiply-add, whose
//   accumulator feeds the next character. A last word is written into the
//   queue, and its result is then held in the result register.
// Reset: radix 10, 64-bit mode, parse state and queue cleared.
// Stall: while rsp_ready is low the result is held; non-last words keep
//   flowing, a further last word waits in the two-word queue, and req_ready
//   drops only when that queue is full.
module ascii_radix_integer_parser
   import arip_pkg::*;
#(
   parameter int unsigned MAX_LEN = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RADIX_W-1:0] radix_ff;
   logic               wide_mode_ff;

   logic    q_full;
   logic    q_push;
   cls_type q_push_data;
   logic    q_pop;
   logic    q_valid;
   cls_type q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         wide_mode_ff <= WIDE_MODE_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_RADIX:     radix_ff     <= csr_wdata[RADIX_W-1:0];
            CSR_WIDE_MODE: wide_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // classify incoming characters
   arip_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // decouples acceptance from the parse loop
   arip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   // parse state, accumulate, result register
   arip_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .radix     (radix_ff),
      .wide_mode (wide_mode_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
